FILE: rtl/core/flog2_pkg.sv
// Shared widths, constants and types of the fixed-point base-2 logarithm block.
package flog2_pkg;

  // Operand and result formats
  localparam int X_W        = 32;
  localparam int RESULT_W   = 23;

  // Normalization word: the operand without its sign bit
  localparam int NORM_W     = 31;
  localparam int NORM_STEPS = 5;

  // Mantissa in [1,2) with MANT_POINT fraction bits
  localparam int MANT_POINT = 27;
  localparam int MANT_W     = MANT_POINT + 1;
  localparam int SQ_W       = MANT_W + 1;
  localparam int PROD_W     = 2 * MANT_W;

  // Truncated square operand shifts
  localparam int FAST_SHIFT_A = 13;
  localparam int FAST_SHIFT_B = 14;

  // Signed exponent, covers -32 .. 31
  localparam int EXP_W      = 6;

  // One squaring round: next mantissa and the result bit it yields
  typedef struct packed {
    logic              halved;
    logic [MANT_W-1:0] mant;
  } sqr_res_t;

endpackage

FILE: rtl/core/flog2_sqr.sv
// Shared squaring unit: one exact or truncated square and the halving step per round.
module flog2_sqr
  import flog2_pkg::*;
(
  input  logic              fast_mode,
  input  logic [MANT_W-1:0] mant,
  output sqr_res_t          res
);

  logic [MANT_W-1:0] op_a;
  logic [MANT_W-1:0] op_b;
  logic [PROD_W-1:0] prod;
  logic [SQ_W-1:0]   sq;

  // Pick operands for the single multiplier
  always_comb begin
    if (fast_mode) begin
      op_a = MANT_W'(mant >> FAST_SHIFT_A);
      op_b = MANT_W'(mant >> FAST_SHIFT_B);
    end else begin
      op_a = mant;
      op_b = mant;
    end
  end

  assign prod = op_a * op_b;

  // Exact mode rescales the full product; fast mode already sits at the point
  assign sq = fast_mode ? prod[SQ_W-1:0] : prod[PROD_W-1:MANT_POINT];

  // Halve when the square reaches 2.0 and emit a one bit
  always_comb begin
    res.halved = sq[SQ_W-1];
    res.mant   = sq[SQ_W-1] ? sq[SQ_W-1:1] : sq[MANT_W-1:0];
  end

endmodule

FILE: rtl/core/fixed_point_log2_top.sv
// Fixed-point base-2 logarithm: leading-zero normalizer plus iterative squaring loop.
//
// Pulse start with x_value while busy is low; the operand is a signed number with
// FRAC_BITS fraction bits and must be positive. A zero or negative operand returns
// done in the next cycle with invalid_input set and log_result zero. For a valid
// operand, five steps of a halving shift search find the leading one, then one
// shared multiplier squares the mantissa once per fraction bit. busy is high from
// the cycle after acceptance until done is shown; a new transaction can be started
// in the same cycle done is high, but not before the last one is done. done lasts
// one cycle and the receiver must take it then. fast_mode, written through
// cfg_write_en and cfg_write_data, selects the truncated square in place of the
// exact one; the user must write it only while idle, the block does not enforce it.
module fixed_point_log2_top
  import flog2_pkg::*;
#(
  parameter int FRAC_BITS = 17
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic                       cfg_write_data,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [X_W-1:0]      x_value,
  output logic                       done,
  output logic signed [RESULT_W-1:0] log_result,
  output logic                       invalid_input
);

  localparam int CNT_W = $clog2(FRAC_BITS);
  localparam logic [CNT_W-1:0] CNT_NORM_LAST = CNT_W'(NORM_STEPS - 1);
  localparam logic [CNT_W-1:0] CNT_SQR_LAST  = CNT_W'(FRAC_BITS - 1);
  localparam logic signed [EXP_W-1:0] EXP_INIT = EXP_W'(NORM_W - 1 - FRAC_BITS);
  localparam logic [MANT_W-1:0] LOW_MASK =
    MANT_W'((64'd1 << (MANT_POINT - FRAC_BITS)) - 64'd1);
  localparam int FULL_W = EXP_W + FRAC_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQR
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         cnt;
  logic                     fast_mode;
  logic [NORM_W-1:0]        norm_w;
  logic signed [EXP_W-1:0]  exponent;
  logic [MANT_W-1:0]        mant;
  logic [FRAC_BITS-1:0]     frac;

  logic [4:0]               shift_amt;
  logic                     top_zero;
  logic [NORM_W-1:0]        norm_w_next;
  logic signed [EXP_W-1:0]  exponent_next;
  logic [FRAC_BITS-1:0]     frac_next;
  logic signed [FULL_W-1:0] full_result;
  logic                     x_bad;
  sqr_res_t                 sq;

  flog2_sqr u_sqr (
    .fast_mode (fast_mode),
    .mant      (mant),
    .res       (sq)
  );

  assign busy  = (state != ST_IDLE);
  assign x_bad = (x_value == '0) || x_value[X_W-1];

  // One step of the leading-zero search: shift by 16, 8, 4, 2, 1
  always_comb begin
    shift_amt = 5'(5'd16 >> cnt);
    top_zero  = ((norm_w >> (NORM_W - int'(shift_amt))) == '0);
    if (top_zero) begin
      norm_w_next   = norm_w << shift_amt;
      exponent_next = exponent - EXP_W'(shift_amt);
    end else begin
      norm_w_next   = norm_w;
      exponent_next = exponent;
    end
  end

  // Shift in the result bit of this round and assemble the fixed-point result
  assign frac_next   = {frac[FRAC_BITS-2:0], sq.halved};
  assign full_result = {exponent, frac_next};

  // Sequencer, datapath registers and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      done      <= 1'b0;
      fast_mode <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write_en) begin
        fast_mode <= cfg_write_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (x_bad) begin
              done          <= 1'b1;
              log_result    <= '0;
              invalid_input <= 1'b1;
            end else begin
              norm_w   <= x_value[NORM_W-1:0];
              exponent <= EXP_INIT;
              cnt      <= '0;
              state    <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          norm_w   <= norm_w_next;
          exponent <= exponent_next;
          if (cnt == CNT_NORM_LAST) begin
            // Drop the operand bits the fixed-point shift would lose
            mant  <= norm_w_next[NORM_W-1 -: MANT_W] & ~LOW_MASK;
            cnt   <= '0;
            state <= ST_SQR;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_SQR: begin
          mant <= sq.mant;
          frac <= frac_next;
          if (cnt == CNT_SQR_LAST) begin
            done          <= 1'b1;
            log_result    <= RESULT_W'(full_result);
            invalid_input <= 1'b0;
            state         <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/flog2_checker.sv
// Port-level checks of the logarithm block and their binding to the top level.
module flog2_checker
  import flog2_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic signed [X_W-1:0]      x_value,
  input logic                       done,
  input logic signed [RESULT_W-1:0] log_result,
  input logic                       invalid_input
);

  // An invalid operand is answered in the next cycle
  a_invalid_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && ((x_value == '0) || x_value[X_W-1]))
    |=> (done && invalid_input))
    else $error("invalid operand not flagged in the next cycle");

  // A valid operand starts the iteration
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (x_value != '0) && !x_value[X_W-1]) |=> (busy && !done))
    else $error("valid operand did not start the iteration");

  // No result strobe while an operand is in progress
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Flagged transactions carry a zero result
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && invalid_input) |-> (log_result == '0))
    else $error("invalid transaction with nonzero result");

endmodule

bind fixed_point_log2_top flog2_checker u_flog2_checker (.*);
